@@ src/rcwt_pkg.sv @@
// Shared types and constants for the Reno congestion window tracker.
// Holds the transfer payload structs, the event and phase codes, and the sequencer states.
// No dependencies.
package rcwt_pkg;

    // Event codes carried in the mode field.
    localparam logic [1:0] MODE_SENT    = 2'd0;
    localparam logic [1:0] MODE_ACK     = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_INIT_THRESH = 2'd0;
    localparam logic [1:0] REG_MAX_WINDOW  = 2'd1;
    localparam logic [1:0] REG_DUP_LIMIT   = 2'd2;
    localparam logic [1:0] REG_INFLATE     = 2'd3;

    // Reset values of the configuration registers and of the threshold.
    localparam logic [15:0] INIT_THRESH_RST = 16'd64;
    localparam logic [8:0]  MAX_WINDOW_RST  = 9'd256;
    localparam logic [2:0]  DUP_LIMIT_RST   = 3'd3;
    localparam logic [2:0]  INFLATE_RST     = 3'd3;

    // Largest window the tracker ever holds, and the duplicate count ceiling.
    localparam logic [8:0]  WINDOW_LIMIT = 9'd256;
    localparam logic [2:0]  DUP_SAT      = 3'd7;

    typedef enum logic [1:0] {
        PH_SLOW  = 2'd0,
        PH_AVOID = 2'd1,
        PH_RECOV = 2'd2
    } t_phase;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_SLOT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MACH,
        ST_INFL,
        ST_SLOW2,
        ST_AVOID2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] packet_id;
        logic [15:0] ack_seq;
        logic        intact;
    } t_in_item;

    typedef struct packed {
        logic [15:0] send_base;
        logic [8:0]  window;
        logic [15:0] threshold;
        logic [1:0]  phase;
        logic        retransmit;
        logic        status;
    } t_out_item;

endpackage

@@ src/rcwt_alu.sv @@
// Shared 16-bit add/subtract and unsigned compare unit of the tracker.
// Depends on rcwt_pkg for the operation code.
module rcwt_alu import rcwt_pkg::*; (
    input  t_alu_op     i_op,
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [15:0] o_res,
    output logic        o_lt
);

    always_comb begin
        case (i_op)
            ALU_ADD: o_res = i_a + i_b;
            ALU_SUB: o_res = i_a - i_b;
            default: o_res = i_a + i_b;
        endcase
    end

    assign o_lt = (i_a < i_b);

endmodule

@@ src/rcwt_bitmap.sv @@
// Acknowledged-bit ring of the tracker: one bit per tracked packet slot.
// After reset a sweep clears one slot per cycle; o_ready is low until it finishes.
// Depends on rcwt_pkg only by convention of the project.
module rcwt_bitmap import rcwt_pkg::*; #(
    parameter int RING_DEPTH = 256,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata,
    output logic          o_ready
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    logic          r_mem [RING_DEPTH];
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_SLOT) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            if (r_busy) begin
                r_mem[r_clr_addr] <= 1'b0;
            end else if (i_we) begin
                r_mem[i_waddr] <= i_wdata;
            end
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_busy;

endmodule

@@ src/reno_congestion_window_tracker.sv @@
// Sender-side TCP Reno congestion window tracker, counted in packets. Each input transfer
// is one event (packet sent, acknowledgement, or timeout) and yields exactly one result
// transfer with the send base, window, threshold and phase after the event. A small
// sequencer runs every event through one shared 16-bit add/compare unit. A sent packet,
// a timeout, a corrupted acknowledgement or an undefined event code passes the offset and
// slot steps and then loads the result register; the sequencer goes back to idle before
// it takes the next event, so a new event is taken only once the last one is through. An
// intact acknowledgement outside the ring also runs the first step of the congestion
// machine, and its second step when the machine needs it (a new acknowledgement in slow
// start or congestion avoidance, or fast recovery entry). An intact acknowledgement inside
// the ring first moves the send base over every acknowledged packet ahead of it; each
// step of that scan is one read and, for a set bit, one clear of the acknowledged-bit
// memory, whose single read port sets the pace; the worst case passes a full ring of 256
// slots. A new transfer is taken while the previous result still waits to be collected;
// the next result is loaded only once that one has gone. After reset the acknowledged-bit
// memory is swept clear, one slot per cycle, and no input transfer is taken until the
// sweep ends; register writes work throughout.
// Depends on rcwt_pkg, rcwt_alu and rcwt_bitmap.
module reno_congestion_window_tracker import rcwt_pkg::*; #(
    parameter int RING_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Event input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,

    // Result output channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,

    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [15:0]   DEPTH16   = 16'(RING_DEPTH);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    // Configuration registers. The window ceiling is kept pre-clamped to 1..256.
    logic [15:0] r_init_thr;
    logic [8:0]  r_max_win;
    logic [8:0]  r_ceil;
    logic [2:0]  r_dup_lim;
    logic [2:0]  r_inflate;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [8:0]  wr_win;

    // Sequencer and tracker state.
    t_state      r_state, n_state;
    t_in_item    r_item, n_item;
    logic [15:0] r_offset, n_offset;
    logic [15:0] r_base, n_base;
    logic [AW-1:0] r_base_slot, n_base_slot;
    logic [8:0]  r_window, n_window;
    logic [15:0] r_thresh, n_thresh;
    t_phase      r_phase, n_phase;
    logic [2:0]  r_dup, n_dup;
    logic [8:0]  r_credit, n_credit;
    logic [15:0] r_last_ack, n_last_ack;
    logic        r_retx, n_retx;
    logic        r_stat, n_stat;
    t_out_item   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    // Shared unit and bitmap hookup.
    t_alu_op     alu_op;
    logic [15:0] alu_a, alu_b, alu_res;
    logic        alu_lt;
    logic        bm_we, bm_wdata, bm_rdata, bm_ready;
    logic [AW-1:0] bm_waddr;

    logic        accept;
    logic        in_ring;
    logic [AW:0] slot_sum;
    logic [AW-1:0] slot;
    logic        dup_ack;
    logic [2:0]  dup_next;

    // Clamp a grown window to the configured ceiling.
    function automatic logic [8:0] f_cap(input logic [9:0] v, input logic [8:0] c);
        f_cap = (v > {1'b0, c}) ? c : v[8:0];
    endfunction

    //--------------------------------------------------------------------------
    // Register port. Every access completes in its access phase.
    //--------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];
    assign wr_win    = pwdata[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_thr <= INIT_THRESH_RST;
            r_max_win  <= MAX_WINDOW_RST;
            r_ceil     <= MAX_WINDOW_RST;
            r_dup_lim  <= DUP_LIMIT_RST;
            r_inflate  <= INFLATE_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_INIT_THRESH: r_init_thr <= pwdata[15:0];
                REG_MAX_WINDOW: begin
                    r_max_win <= wr_win;
                    if (wr_win == 9'd0) begin
                        r_ceil <= 9'd1;
                    end else if (wr_win > WINDOW_LIMIT) begin
                        r_ceil <= WINDOW_LIMIT;
                    end else begin
                        r_ceil <= wr_win;
                    end
                end
                REG_DUP_LIMIT:   r_dup_lim <= pwdata[2:0];
                REG_INFLATE:     r_inflate <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_INIT_THRESH: prdata = {16'd0, r_init_thr};
            REG_MAX_WINDOW:  prdata = {23'd0, r_max_win};
            REG_DUP_LIMIT:   prdata = {29'd0, r_dup_lim};
            REG_INFLATE:     prdata = {29'd0, r_inflate};
            default:         prdata = 32'd0;
        endcase
    end

    //--------------------------------------------------------------------------
    // Shared arithmetic unit and acknowledged-bit ring.
    //--------------------------------------------------------------------------
    rcwt_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res),
        .o_lt  (alu_lt)
    );

    // The read port always looks at the slot under the send base.
    rcwt_bitmap #(.RING_DEPTH(RING_DEPTH)) u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (r_base_slot),
        .o_rdata (bm_rdata),
        .o_ready (bm_ready)
    );

    //--------------------------------------------------------------------------
    // Handshakes. The result register lets a new event in while a result waits.
    //--------------------------------------------------------------------------
    assign o_in_stall  = !((r_state == ST_IDLE) && bm_ready);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A packet is tracked when its distance from the send base fits in the ring.
    assign in_ring  = (r_offset < DEPTH16);
    assign slot_sum = alu_res[AW:0];
    assign slot     = (slot_sum >= DEPTH_EXT) ? AW'(slot_sum - DEPTH_EXT) : slot_sum[AW-1:0];
    assign dup_ack  = (r_item.ack_seq == r_last_ack);
    assign dup_next = (r_dup == DUP_SAT) ? DUP_SAT : r_dup + 3'd1;

    //--------------------------------------------------------------------------
    // Sequencer: next state, shared unit operands and state updates.
    //--------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_offset    = r_offset;
        n_base      = r_base;
        n_base_slot = r_base_slot;
        n_window    = r_window;
        n_thresh    = r_thresh;
        n_phase     = r_phase;
        n_dup       = r_dup;
        n_credit    = r_credit;
        n_last_ack  = r_last_ack;
        n_retx      = r_retx;
        n_stat      = r_stat;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        alu_op      = ALU_ADD;
        alu_a       = r_item.packet_id;
        alu_b       = r_base;
        bm_we       = 1'b0;
        bm_wdata    = 1'b0;
        bm_waddr    = r_base_slot;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item  = i_in;
                    n_retx  = 1'b0;
                    n_stat  = 1'b0;
                    n_state = ST_OFFSET;
                end
            end

            // Distance of the packet from the send base, modulo 2^16.
            ST_OFFSET: begin
                alu_op   = ALU_SUB;
                alu_a    = r_item.packet_id;
                alu_b    = r_base;
                n_offset = alu_res;
                n_state  = ST_SLOT;
            end

            // Ring slot of the packet, then dispatch on the event kind.
            ST_SLOT: begin
                alu_op   = ALU_ADD;
                alu_a    = 16'(r_base_slot);
                alu_b    = r_offset;
                bm_waddr = slot;
                n_state  = ST_DONE;
                case (r_item.mode)
                    MODE_SENT: begin
                        if (in_ring) begin
                            bm_we    = 1'b1;
                            bm_wdata = 1'b0;
                        end else begin
                            n_stat = 1'b1;
                        end
                    end
                    MODE_ACK: begin
                        if (!r_item.intact) begin
                            n_retx = 1'b1;
                        end else if (in_ring) begin
                            bm_we    = 1'b1;
                            bm_wdata = 1'b1;
                            n_state  = ST_SCAN_RD;
                        end else begin
                            n_stat  = 1'b1;
                            n_state = ST_MACH;
                        end
                    end
                    MODE_TIMEOUT: begin
                        n_phase  = PH_SLOW;
                        n_thresh = {7'd0, r_window[8:0]} >> 1;
                        n_window = 9'd1;
                        n_dup    = 3'd0;
                        n_credit = 9'd0;
                    end
                    default: ;
                endcase
            end

            // Read the bit under the send base; the data is there next cycle.
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end

            // A set bit is cleared and the base moves on by one packet.
            ST_SCAN_CHK: begin
                if (bm_rdata) begin
                    bm_we       = 1'b1;
                    bm_wdata    = 1'b0;
                    bm_waddr    = r_base_slot;
                    alu_op      = ALU_ADD;
                    alu_a       = r_base;
                    alu_b       = 16'd1;
                    n_base      = alu_res;
                    n_base_slot = (r_base_slot == LAST_SLOT) ? '0 : r_base_slot + AW'(1);
                    n_state     = ST_SCAN_RD;
                end else begin
                    n_state = ST_MACH;
                end
            end

            // First step of the congestion machine for an intact acknowledgement.
            ST_MACH: begin
                n_state = ST_DONE;
                if (dup_ack) begin
                    if (r_phase == PH_RECOV) begin
                        n_window = f_cap(10'(r_window) + 10'd1, r_ceil);
                    end else begin
                        n_dup = dup_next;
                        if (dup_next == r_dup_lim) begin
                            n_thresh = {7'd0, r_window[8:0]} >> 1;
                            n_phase  = PH_RECOV;
                            n_state  = ST_INFL;
                        end
                    end
                end else begin
                    n_last_ack = r_item.ack_seq;
                    n_dup      = 3'd0;
                    case (r_phase)
                        PH_SLOW: begin
                            alu_op = ALU_SUB;
                            alu_a  = {7'd0, r_window};
                            alu_b  = r_thresh;
                            if (alu_lt) begin
                                n_window = f_cap(10'(r_window) + 10'd1, r_ceil);
                            end
                            n_state = ST_SLOW2;
                        end
                        PH_AVOID: begin
                            n_credit = r_credit + 9'd1;
                            n_state  = ST_AVOID2;
                        end
                        PH_RECOV: begin
                            alu_op   = ALU_SUB;
                            alu_a    = r_thresh;
                            alu_b    = {7'd0, r_ceil};
                            n_window = alu_lt ? r_thresh[8:0] : r_ceil;
                            n_phase  = PH_AVOID;
                            n_credit = 9'd0;
                        end
                        default: ;
                    endcase
                end
            end

            // Fast recovery entry: window becomes threshold plus the inflation, capped at the ceiling.
            ST_INFL: begin
                alu_op   = ALU_ADD;
                alu_a    = r_thresh;
                alu_b    = {13'd0, r_inflate};
                n_window = f_cap(alu_res[9:0], r_ceil);
                n_state  = ST_DONE;
            end

            // Slow start is left once the window has reached the threshold.
            ST_SLOW2: begin
                alu_op = ALU_SUB;
                alu_a  = {7'd0, r_window};
                alu_b  = r_thresh;
                if (!alu_lt) begin
                    n_phase  = PH_AVOID;
                    n_credit = 9'd0;
                end
                n_state = ST_DONE;
            end

            // One window's worth of new acknowledgements grows the window by one.
            ST_AVOID2: begin
                if (r_credit >= r_window) begin
                    n_credit = 9'd0;
                    n_window = f_cap(10'(r_window) + 10'd1, r_ceil);
                end
                n_state = ST_DONE;
            end

            // Load the result register once the previous result has been taken.
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.send_base  = r_base;
                    n_out.window     = r_window;
                    n_out.threshold  = r_thresh;
                    n_out.phase      = r_phase;
                    n_out.retransmit = r_retx;
                    n_out.status     = r_stat;
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= 16'd0;
            r_base_slot <= '0;
            r_window    <= 9'd1;
            r_thresh    <= INIT_THRESH_RST;
            r_phase     <= PH_SLOW;
            r_dup       <= 3'd0;
            r_credit    <= 9'd0;
            r_last_ack  <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_base      <= n_base;
            r_base_slot <= n_base_slot;
            r_window    <= n_window;
            r_thresh    <= n_thresh;
            r_phase     <= n_phase;
            r_dup       <= n_dup;
            r_credit    <= n_credit;
            r_last_ack  <= n_last_ack;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_offset <= n_offset;
        r_retx   <= n_retx;
        r_stat   <= n_stat;
        r_out    <= n_out;
    end

    //--------------------------------------------------------------------------
    // Assertions.
    //--------------------------------------------------------------------------

    // A new result only appears after the sequencer has finished an event.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result appeared without a finished event");

    // No event is taken while the bit ring is still being swept clear.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> bm_ready)
        else $error("event accepted during the clearing sweep");

    // The send base moves by at most one packet per cycle.
    a_base_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_base != $past(r_base))) |-> (r_base == $past(r_base) + 16'd1))
        else $error("send base jumped by more than one packet");

    // A retransmit request is never reported together with an ignored packet.
    a_retx_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.retransmit && r_out.status))
        else $error("retransmit and out-of-ring status set together");

endmodule
